### hw/rtl/sac_pkg.sv
// Shared types and constants for the strength attack connectivity unit.
package sac_pkg;

   localparam int                 KIND_W          = 1;
   localparam int                 INDEX_W         = 5;
   localparam int                 STRENGTH_W      = 22;
   localparam int                 COUNT_W         = 6;
   localparam int                 STRENGTH_MAX    = 2097151;
   localparam int                 STRENGTH_MIN    = -2097152;
   localparam logic [COUNT_W-1:0] NODE_COUNT_RST  = 6'd32;
   localparam logic               REG_NODE_COUNT  = 1'b0;
   localparam logic [KIND_W-1:0]  KIND_REMOVAL    = 1'b0;
   localparam logic [KIND_W-1:0]  KIND_COUNT      = 1'b1;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_LOAD_COL = 7'b0000010,
      S_ROOT     = 7'b0000100,
      S_WALK     = 7'b0001000,
      S_PICK     = 7'b0010000,
      S_EMIT     = 7'b0100000,
      S_COUNT    = 7'b1000000
   } state_type;

   typedef struct packed {
      logic clear;
      logic acc;
      logic link;
   } store_ctl_type;

endpackage

### hw/rtl/sac_graph_store.sv
// Adjacency rows and node strength accumulators with one indexed port.
module sac_graph_store #(
   parameter int MAX_NODES = 32,
   parameter int IW        = 5,
   parameter int SW        = 22
) (
   input  logic                    clock,
   input  sac_pkg::store_ctl_type  ctl,
   input  logic [IW-1:0]           idx,
   input  logic [IW-1:0]           other,
   input  logic signed [15:0]      weight,
   output logic [MAX_NODES-1:0]    row_q,
   output logic signed [SW-1:0]    str_q
);

   logic [MAX_NODES-1:0]   edge_ff [MAX_NODES];
   logic signed [SW-1:0]   str_ff  [MAX_NODES];
   logic signed [SW-1:0]   str_base;
   logic [MAX_NODES-1:0]   row_base;
   logic [MAX_NODES-1:0]   other_bit;

   assign row_q     = edge_ff[idx];
   assign str_q     = str_ff[idx];
   assign str_base  = ctl.clear ? '0 : str_ff[idx];
   assign row_base  = ctl.clear ? '0 : edge_ff[idx];
   assign other_bit = MAX_NODES'(1) << other;

   always_ff @(posedge clock) begin
      for (int e = 0; e < MAX_NODES; e++) begin
         if (ctl.acc && (IW'(e) == idx)) begin
            str_ff[e] <= str_base + SW'(weight);
         end else if (ctl.clear) begin
            str_ff[e] <= '0;
         end
         if (ctl.link && (IW'(e) == idx)) begin
            edge_ff[e] <= row_base | other_bit;
         end else if (ctl.clear) begin
            edge_ff[e] <= '0;
         end
      end
   end

endmodule

### hw/rtl/strength_attack_connectivity_unit.sv
// Top level: matrix load, greedy strength attack and connectivity walk.
//
//   channel  | direction | ports                               | handshake
//   req      | in        | req_weight                          | req_valid / req_stall
//   rsp      | out       | rsp_kind .. rsp_last                | rsp_valid / rsp_stall
//   csr      | in/out    | psel penable pwrite paddr pwdata    | pready tied high
//
// For each matrix word the strength adder serves the row entry, then the column; the next word
// is stalled until both are done. The last word starts a run; per removal, one root step, a
// walk pass over n stored rows that repeats until no node joins (at most n passes), a strength
// scan over n nodes and an emit step. A count word ends the run when no node remains or the rest is not connected.
// Reset is synchronous; node_count returns to 32 and loading restarts at row 0, column 0.
// A stalled result holds in the output register; the sequencer waits before the next result.
module strength_attack_connectivity_unit #(
   parameter int MAX_NODES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [15:0]                     req_weight,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sac_pkg::KIND_W-1:0]             rsp_kind,
   output logic [sac_pkg::INDEX_W-1:0]            rsp_node_index,
   output logic signed [sac_pkg::STRENGTH_W-1:0]  rsp_strength,
   output logic [sac_pkg::COUNT_W-1:0]            rsp_removal_count,
   output logic                                   rsp_last,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [2:0]                             paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam int IW = $clog2(MAX_NODES);
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int SW = 17 + $clog2(MAX_NODES);
   localparam int CW = (SW > sac_pkg::STRENGTH_W) ? SW : sac_pkg::STRENGTH_W;
   localparam logic [MAX_NODES-1:0] ALL_NODES = '1;

   sac_pkg::state_type            state_ff, state_in;
   logic [sac_pkg::COUNT_W-1:0]   node_count_ff, node_count_in;
   logic [IW-1:0]                 row_ff, row_in;
   logic [IW-1:0]                 col_ff, col_in;
   logic signed [15:0]            weight_ff, weight_in;
   logic [MAX_NODES-1:0]          present_ff, present_in;
   logic [MAX_NODES-1:0]          visited_ff, visited_in;
   logic                          changed_ff, changed_in;
   logic [IW-1:0]                 scan_ff, scan_in;
   logic [IW-1:0]                 best_ff, best_in;
   logic signed [SW-1:0]          best_s_ff, best_s_in;
   logic                          best_ok_ff, best_ok_in;
   logic [NW-1:0]                 removed_ff, removed_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [sac_pkg::KIND_W-1:0]            rsp_kind_ff, rsp_kind_in;
   logic [sac_pkg::INDEX_W-1:0]           rsp_node_ff, rsp_node_in;
   logic signed [sac_pkg::STRENGTH_W-1:0] rsp_str_ff, rsp_str_in;
   logic [sac_pkg::COUNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic                                  rsp_last_ff, rsp_last_in;

   sac_pkg::store_ctl_type  ctl;
   logic [IW-1:0]           st_idx;
   logic [IW-1:0]           st_other;
   logic signed [15:0]      st_weight;
   logic [MAX_NODES-1:0]    row_q;
   logic signed [SW-1:0]    str_q;

   logic [NW-1:0]           n_act;
   logic [IW-1:0]           n_last;
   logic [MAX_NODES-1:0]    full_mask;
   logic                    csr_wr;
   logic                    req_take;
   logic                    out_free;
   logic                    scan_end;
   logic [MAX_NODES-1:0]    walk_next;
   logic signed [CW-1:0]    best_ext;
   logic signed [sac_pkg::STRENGTH_W-1:0] best_sat;

   always_comb begin
      if (node_count_ff == '0) begin
         n_act = NW'(1);
      end else if ({1'b0, node_count_ff} > 7'(MAX_NODES)) begin
         n_act = NW'(MAX_NODES);
      end else begin
         n_act = NW'(node_count_ff);
      end
   end

   assign n_last    = IW'(n_act - NW'(1));
   assign full_mask = ALL_NODES >> (NW'(MAX_NODES) - n_act);
   assign csr_wr    = psel && penable && pwrite && (paddr[2] == sac_pkg::REG_NODE_COUNT);
   assign req_stall = (state_ff != sac_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_end  = (scan_ff == n_last);
   assign walk_next = visited_ff[scan_ff] ? (visited_ff | (row_q & present_ff)) : visited_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == sac_pkg::REG_NODE_COUNT) ? 32'(node_count_ff) : '0;

   always_comb begin
      best_ext = CW'(best_s_ff);
      if (best_ext > CW'(sac_pkg::STRENGTH_MAX)) begin
         best_sat = sac_pkg::STRENGTH_W'(sac_pkg::STRENGTH_MAX);
      end else if (best_ext < CW'(sac_pkg::STRENGTH_MIN)) begin
         best_sat = sac_pkg::STRENGTH_W'(sac_pkg::STRENGTH_MIN);
      end else begin
         best_sat = best_ext[sac_pkg::STRENGTH_W-1:0];
      end
   end

   always_comb begin
      ctl       = '0;
      st_idx    = scan_ff;
      st_other  = col_ff;
      st_weight = weight_ff;
      unique case (state_ff)
         sac_pkg::S_IDLE: begin
            st_idx    = row_ff;
            st_other  = col_ff;
            st_weight = req_weight;
            ctl.clear = req_take && (row_ff == '0) && (col_ff == '0);
            ctl.acc   = req_take;
            ctl.link  = req_take && (req_weight > 16'sd0);
         end
         sac_pkg::S_LOAD_COL: begin
            st_idx    = col_ff;
            st_other  = row_ff;
            ctl.acc   = 1'b1;
            ctl.link  = (weight_ff > 16'sd0);
         end
         default: begin
         end
      endcase
   end

   sac_graph_store #(
      .MAX_NODES (MAX_NODES),
      .IW        (IW),
      .SW        (SW)
   ) u_store (
      .clock  (clock),
      .ctl    (ctl),
      .idx    (st_idx),
      .other  (st_other),
      .weight (st_weight),
      .row_q  (row_q),
      .str_q  (str_q)
   );

   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      weight_in     = weight_ff;
      present_in    = present_ff;
      visited_in    = visited_ff;
      changed_in    = changed_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_s_in     = best_s_ff;
      best_ok_in    = best_ok_ff;
      removed_in    = removed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_str_in    = rsp_str_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         sac_pkg::S_IDLE: begin
            if (req_take) begin
               weight_in = req_weight;
               state_in  = sac_pkg::S_LOAD_COL;
            end
         end
         sac_pkg::S_LOAD_COL: begin
            if (col_ff != n_last) begin
               col_in   = col_ff + IW'(1);
               state_in = sac_pkg::S_IDLE;
            end else if (row_ff != n_last) begin
               col_in   = '0;
               row_in   = row_ff + IW'(1);
               state_in = sac_pkg::S_IDLE;
            end else begin
               col_in     = '0;
               row_in     = '0;
               present_in = full_mask;
               removed_in = '0;
               state_in   = sac_pkg::S_ROOT;
            end
         end
         sac_pkg::S_ROOT: begin
            if (present_ff == '0) begin
               state_in = sac_pkg::S_COUNT;
            end else begin
               visited_in = present_ff & (~present_ff + MAX_NODES'(1));
               changed_in = 1'b0;
               scan_in    = '0;
               state_in   = sac_pkg::S_WALK;
            end
         end
         sac_pkg::S_WALK: begin
            visited_in = walk_next;
            changed_in = changed_ff || (walk_next != visited_ff);
            scan_in    = scan_ff + IW'(1);
            if (scan_end) begin
               scan_in    = '0;
               changed_in = 1'b0;
               if (!(changed_ff || (walk_next != visited_ff))) begin
                  best_ok_in = 1'b0;
                  state_in   = (walk_next == present_ff) ? sac_pkg::S_PICK
                                                         : sac_pkg::S_COUNT;
               end
            end
         end
         sac_pkg::S_PICK: begin
            if (present_ff[scan_ff] && (!best_ok_ff || (str_q > best_s_ff))) begin
               best_in    = scan_ff;
               best_s_in  = str_q;
               best_ok_in = 1'b1;
            end
            scan_in = scan_ff + IW'(1);
            if (scan_end) begin
               scan_in  = '0;
               state_in = sac_pkg::S_EMIT;
            end
         end
         sac_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = sac_pkg::KIND_REMOVAL;
               rsp_node_in  = sac_pkg::INDEX_W'(best_ff);
               rsp_str_in   = best_sat;
               rsp_count_in = '0;
               rsp_last_in  = 1'b0;
               present_in   = present_ff & ~(MAX_NODES'(1) << best_ff);
               removed_in   = removed_ff + NW'(1);
               state_in     = sac_pkg::S_ROOT;
            end
         end
         sac_pkg::S_COUNT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = sac_pkg::KIND_COUNT;
               rsp_node_in  = '0;
               rsp_str_in   = '0;
               rsp_count_in = sac_pkg::COUNT_W'(removed_ff);
               rsp_last_in  = 1'b1;
               state_in     = sac_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sac_pkg::S_IDLE;
         end
      endcase

      if (csr_wr) begin
         node_count_in = pwdata[sac_pkg::COUNT_W-1:0];
         row_in        = '0;
         col_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sac_pkg::S_IDLE;
         node_count_ff <= sac_pkg::NODE_COUNT_RST;
         row_ff        <= '0;
         col_ff        <= '0;
         present_ff    <= '0;
         visited_ff    <= '0;
         changed_ff    <= 1'b0;
         scan_ff       <= '0;
         best_ok_ff    <= 1'b0;
         removed_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         present_ff    <= present_in;
         visited_ff    <= visited_in;
         changed_ff    <= changed_in;
         scan_ff       <= scan_in;
         best_ok_ff    <= best_ok_in;
         removed_ff    <= removed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      weight_ff    <= weight_in;
      best_ff      <= best_in;
      best_s_ff    <= best_s_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_str_ff   <= rsp_str_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_node_index    = rsp_node_ff;
   assign rsp_strength      = rsp_str_ff;
   assign rsp_removal_count = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   a_emit_drops_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sac_pkg::S_EMIT && out_free) |=>
         ($countones(present_ff) == $countones($past(present_ff)) - 1))
      else $error("removal did not drop exactly one node");

   a_emit_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sac_pkg::S_EMIT) |-> (best_ok_ff && present_ff[best_ff]))
      else $error("chosen node is not present");

   a_walk_subset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sac_pkg::S_WALK) |-> ((visited_ff & ~present_ff) == '0))
      else $error("walk reached a removed node");

   a_run_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sac_pkg::S_ROOT || state_ff == sac_pkg::S_PICK ||
       state_ff == sac_pkg::S_EMIT || state_ff == sac_pkg::S_COUNT) |->
         (($countones(present_ff) + int'(removed_ff)) == int'(n_act)))
      else $error("removed and present nodes do not add up");

endmodule
